// ===== sv/hds_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the heat diffusion stencil pass.
// Used by hds_addr_gen, hds_stencil, the top level and the bench; depends on nothing.

package hds_pkg;

  // Default sizes handed down as top-level parameter defaults
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_TEMP_BITS = 16;

  // Register widths
  localparam int GRID_WIDTH_BITS  = 12;
  localparam int GRID_HEIGHT_BITS = 13;
  localparam int FACTOR_BITS      = 16;
  localparam int CFG_ADDR_BITS    = 2;
  localparam int CFG_DATA_BITS    = 16;

  // Row counter runs up to grid_height + 1
  localparam int ROW_BITS = GRID_HEIGHT_BITS + 1;

  // Smallest legal grid dimension
  localparam int MIN_DIM = 3;

  // Register reset values
  localparam logic [GRID_WIDTH_BITS-1:0]  RESET_GRID_WIDTH  = GRID_WIDTH_BITS'(2000);
  localparam logic [GRID_HEIGHT_BITS-1:0] RESET_GRID_HEIGHT = GRID_HEIGHT_BITS'(2000);
  localparam logic [FACTOR_BITS-1:0]      RESET_FACTOR      = FACTOR_BITS'(16384);

  // Factor is Q0.16: product scaled down by 2^16, rounded half up
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

  // Result queue depth
  localparam int OUT_FIFO_DEPTH = 8;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_GRID_WIDTH       = 2'd0,
    REG_GRID_HEIGHT      = 2'd1,
    REG_DIFFUSION_FACTOR = 2'd2
  } cfg_reg_t;

  // Per-item control that travels down the stencil pipeline
  typedef struct packed {
    logic valid;  // item entered the pipe (not an ignored drain)
    logic have;   // item puts out a cell
    logic pass;   // edge cell: copy center
    logic last;   // final cell of the grid
    logic wrap;   // column zero: cell is the end of the row two back
    logic fwd;    // wrap cell still in the previous item's registers
  } cell_ctl_t;

endpackage

// ===== sv/hds_line_buf.sv =====
`timescale 1ns / 1ps
// Line store: one entry per column holding {row above, current row}.
// One write port, two registered read ports. Uses no package items.

module hds_line_buf #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     ra_en,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [DATA_W-1:0]        ra_data,
  input  logic                     rb_en,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [DATA_W-1:0]        rb_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // reads return the old entry on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ra_en) begin
      ra_data <= mem[ra_addr];
    end
    if (rb_en) begin
      rb_data <= mem[rb_addr];
    end
  end

endmodule

// ===== sv/hds_addr_gen.sv =====
`timescale 1ns / 1ps
// Input position tracking and per-item decode of the output cell.
// Depends on hds_pkg (cell_ctl_t, register widths).

module hds_addr_gen #(
  parameter int MAX_WIDTH = hds_pkg::DEF_MAX_WIDTH,
  parameter int TEMP_BITS = hds_pkg::DEF_TEMP_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_fire,
  input  logic [TEMP_BITS-1:0]                  old_temp,
  input  logic                                  drain,
  input  logic [hds_pkg::GRID_WIDTH_BITS-1:0]   grid_width,
  input  logic [hds_pkg::GRID_HEIGHT_BITS-1:0]  grid_height,
  output hds_pkg::cell_ctl_t                    ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]          cell_col,
  output logic [TEMP_BITS-1:0]                  cell_temp,
  output logic [$clog2(MAX_WIDTH)-1:0]          wrap_col
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = hds_pkg::ROW_BITS;

  logic [COL_W-1:0] in_column, in_column_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] last_col;

  logic [COL_W:0]   w_eff;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] h_eff, hp1;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic             pos_bad, in_data, have_a, have_b;

  // clamp the grid size to the legal range
  always_comb begin
    if (grid_width < hds_pkg::GRID_WIDTH_BITS'(hds_pkg::MIN_DIM)) begin
      w_eff = (COL_W+1)'(hds_pkg::MIN_DIM);
    end else if (int'(grid_width) > MAX_WIDTH) begin
      w_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_W+1)'(grid_width);
    end
    if (grid_height < hds_pkg::GRID_HEIGHT_BITS'(hds_pkg::MIN_DIM)) begin
      h_eff = ROW_W'(hds_pkg::MIN_DIM);
    end else begin
      h_eff = ROW_W'(grid_height);
    end
  end

  assign wm1      = COL_W'(w_eff - (COL_W+1)'(1));
  assign hp1      = h_eff + ROW_W'(1);
  assign wrap_col = wm1;

  always_comb begin
    pos_bad = (in_column > wm1) || (in_row > hp1) ||
              ((in_row == hp1) && (in_column != '0));
    cur_col = pos_bad ? '0 : in_column;
    cur_row = pos_bad ? '0 : in_row;

    in_data   = cur_row < h_eff;
    cell_temp = in_data ? old_temp : '0;
    cell_col  = cur_col;

    // cell (row-1, col-1) or, at column zero, the end of row-2
    have_a = (cur_col != '0) && (cur_row != '0);
    have_b = (cur_col == '0) && (cur_row >= ROW_W'(2));

    ctl.valid = in_fire && !(in_data && drain);
    ctl.have  = ctl.valid && (have_a || have_b);
    ctl.wrap  = have_b;
    ctl.fwd   = last_col == wm1;
    ctl.last  = have_b && (cur_row == hp1);
    ctl.pass  = have_b || (cur_row == ROW_W'(1)) || (cur_row == h_eff) ||
                (cur_col == COL_W'(1));

    if (ctl.last) begin
      in_column_next = '0;
      in_row_next    = '0;
    end else if (cur_col == wm1) begin
      in_column_next = '0;
      in_row_next    = cur_row + ROW_W'(1);
    end else begin
      in_column_next = cur_col + COL_W'(1);
      in_row_next    = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      last_col  <= '0;
    end else if (ctl.valid) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
      last_col  <= cur_col;
    end else if (in_fire && pos_bad) begin
      // an ignored drain still restarts an out-of-range position
      in_column <= '0;
      in_row    <= '0;
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    ctl.valid && ctl.last |=> (in_column == '0) && (in_row == '0))
    else $error("position not back at cell zero after the final cell");

  a_position_moves: assert property (@(posedge clk) disable iff (rst)
    ctl.valid && !ctl.last |=> (in_column != '0) || (in_row != '0))
    else $error("position returned to cell zero mid-frame");

endmodule

// ===== sv/hds_stencil.sv =====
`timescale 1ns / 1ps
// Neighbor window and three-stage five-point update: laplacian, product, round/saturate.
// Depends on hds_pkg (cell_ctl_t, FRAC_BITS, ROUND_HALF, FACTOR_BITS).

module hds_stencil #(
  parameter int MAX_WIDTH = hds_pkg::DEF_MAX_WIDTH,
  parameter int TEMP_BITS = hds_pkg::DEF_TEMP_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hds_pkg::cell_ctl_t                ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]      cell_col,
  input  logic [TEMP_BITS-1:0]              cell_temp,
  input  logic [hds_pkg::FACTOR_BITS-1:0]   factor,
  input  logic [2*TEMP_BITS-1:0]            rd_data,
  input  logic [2*TEMP_BITS-1:0]            rd_wrap,
  output logic                              mem_we,
  output logic [$clog2(MAX_WIDTH)-1:0]      mem_waddr,
  output logic [2*TEMP_BITS-1:0]            mem_wdata,
  output logic                              push,
  output logic [TEMP_BITS-1:0]              push_temp,
  output logic                              push_last,
  output logic [1:0]                        inflight
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int LAP_W  = TEMP_BITS + 3;
  localparam int PROD_W = LAP_W + hds_pkg::FACTOR_BITS + 1;
  localparam int RES_W  = PROD_W + 2;
  localparam logic signed [RES_W-1:0] HALF = RES_W'(hds_pkg::ROUND_HALF);

  // stage 1: item with its line store read
  hds_pkg::cell_ctl_t s1_ctl;
  logic [COL_W-1:0]     s1_col;
  logic [TEMP_BITS-1:0] s1_temp;
  logic [TEMP_BITS-1:0] rd_above, rd_cur, wrap_above;

  // earlier items' values: up/center/left/down of the output cell
  logic [TEMP_BITS-1:0] prev_a2, prev_c1, prev2_c1, prev_v;

  logic [TEMP_BITS-1:0]   center;
  logic [TEMP_BITS+1:0]   nsum;
  logic signed [LAP_W-1:0] lap;

  // stage 2
  hds_pkg::cell_ctl_t      s2_ctl;
  logic signed [LAP_W-1:0] s2_lap;
  logic [TEMP_BITS-1:0]    s2_center;
  logic signed [PROD_W-1:0] lap_x, fac_x;

  // stage 3
  hds_pkg::cell_ctl_t       s3_ctl;
  logic signed [PROD_W-1:0] s3_prod;
  logic [TEMP_BITS-1:0]     s3_center;
  logic signed [RES_W-1:0]  q, delta, res;

  assign rd_above   = rd_data[2*TEMP_BITS-1:TEMP_BITS];
  assign rd_cur     = rd_data[TEMP_BITS-1:0];
  assign wrap_above = rd_wrap[2*TEMP_BITS-1:TEMP_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      s3_ctl <= '0;
    end else begin
      s1_ctl <= ctl;
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      s1_col  <= cell_col;
      s1_temp <= cell_temp;
    end
    if (s1_ctl.valid) begin
      prev_a2  <= rd_above;
      prev_c1  <= rd_cur;
      prev2_c1 <= prev_c1;
      prev_v   <= s1_temp;
    end
  end

  // shift the column down one row: above <= current, current <= new
  assign mem_we    = s1_ctl.valid;
  assign mem_waddr = s1_col;
  assign mem_wdata = {rd_cur, s1_temp};

  always_comb begin
    if (s1_ctl.wrap && !s1_ctl.fwd) begin
      center = wrap_above;
    end else begin
      center = prev_c1;
    end
    nsum = (TEMP_BITS+2)'(prev_a2) + (TEMP_BITS+2)'(prev_v) +
           (TEMP_BITS+2)'(prev2_c1) + (TEMP_BITS+2)'(rd_cur);
    lap  = $signed(LAP_W'(nsum)) - $signed(LAP_W'(center) << 2);
  end

  always_ff @(posedge clk) begin
    s2_lap    <= lap;
    s2_center <= center;
  end

  assign lap_x = PROD_W'(s2_lap);
  assign fac_x = $signed(PROD_W'(factor));

  always_ff @(posedge clk) begin
    s3_prod   <= lap_x * fac_x;
    s3_center <= s2_center;
  end

  // arithmetic shift of (prod + half) floors: round half toward +inf
  always_comb begin
    q     = RES_W'(s3_prod) + HALF;
    delta = q >>> hds_pkg::FRAC_BITS;
    res   = delta + $signed(RES_W'(s3_center));
    if (s3_ctl.pass) begin
      push_temp = s3_center;
    end else if (res[RES_W-1]) begin
      push_temp = '0;
    end else if (res[RES_W-2:TEMP_BITS] != '0) begin
      push_temp = '1;
    end else begin
      push_temp = res[TEMP_BITS-1:0];
    end
  end

  assign push      = s3_ctl.have;
  assign push_last = s3_ctl.last;
  assign inflight  = 2'(s1_ctl.have) + 2'(s2_ctl.have) + 2'(s3_ctl.have);

endmodule

// ===== sv/hds_out_fifo.sv =====
`timescale 1ns / 1ps
// Result queue between the fixed-latency pipeline and the output stream.
// Uses no package items; depth and width come from the top level.

module hds_out_fifo #(
  parameter int DEPTH  = 8,
  parameter int DATA_W = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [DATA_W-1:0]          push_data,
  input  logic                       push_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [DATA_W-1:0]          out_data,
  output logic                       out_last,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [DATA_W:0]  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic             pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr][DATA_W-1:0];
  assign out_last  = slots[rd_ptr][DATA_W];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= {push_last, push_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNT_W'(DEPTH))
    else $error("result pushed into a full queue");

endmodule

// ===== sv/heat_diffusion_stencil_pass.sv =====
`timescale 1ns / 1ps
// Top level: one explicit time step of the 2D heat equation on a streamed grid.
// Depends on hds_pkg, hds_addr_gen, hds_line_buf, hds_stencil, hds_out_fifo.
//
//  channel | signals                        | moves
//  --------+--------------------------------+---------------------------------
//  s_axis  | tvalid tready tdata tuser      | old cell temperature, drain flag
//  m_axis  | tvalid tready tdata tlast      | new cell temperature, final cell
//  cfg     | cfg_we cfg_addr cfg_wdata      | grid_width, grid_height, factor
//
// One item per cycle while s_axis_tready is high; the result an item causes
// passes line store read, laplacian, multiply and round/saturate in turn.
// s_axis_tready drops only when the 8-entry result queue plus the items in
// flight would fill it; the pipeline itself never stalls.
// Synchronous reset clears counters and the queue; line stores are not cleared.

module heat_diffusion_stencil_pass #(
  parameter int MAX_WIDTH = hds_pkg::DEF_MAX_WIDTH,
  parameter int TEMP_BITS = hds_pkg::DEF_TEMP_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((TEMP_BITS+7)/8)*8-1:0]      s_axis_tdata,  // old_temp
  input  logic                                s_axis_tuser,  // drain
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((TEMP_BITS+7)/8)*8-1:0]      m_axis_tdata,  // new_temp
  output logic                                m_axis_tlast,
  input  logic                                cfg_we,
  input  logic [hds_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [hds_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int TDATA_W = ((TEMP_BITS + 7) / 8) * 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int DEPTH   = hds_pkg::OUT_FIFO_DEPTH;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  logic [hds_pkg::GRID_WIDTH_BITS-1:0]  grid_width;
  logic [hds_pkg::GRID_HEIGHT_BITS-1:0] grid_height;
  logic [hds_pkg::FACTOR_BITS-1:0]      diffusion_factor;

  logic                   in_fire;
  hds_pkg::cell_ctl_t     ctl;
  logic [COL_W-1:0]       cell_col, wrap_col, mem_waddr;
  logic [TEMP_BITS-1:0]   cell_temp, push_temp, out_temp;
  logic [2*TEMP_BITS-1:0] rd_data, rd_wrap, mem_wdata;
  logic                   mem_we, push, push_last;
  logic [1:0]             inflight;
  logic [CNT_W-1:0]       fifo_count;
  logic [CNT_W:0]         outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= hds_pkg::RESET_GRID_WIDTH;
      grid_height      <= hds_pkg::RESET_GRID_HEIGHT;
      diffusion_factor <= hds_pkg::RESET_FACTOR;
    end else if (cfg_we) begin
      case (hds_pkg::cfg_reg_t'(cfg_addr))
        hds_pkg::REG_GRID_WIDTH: begin
          grid_width <= cfg_wdata[hds_pkg::GRID_WIDTH_BITS-1:0];
        end
        hds_pkg::REG_GRID_HEIGHT: begin
          grid_height <= cfg_wdata[hds_pkg::GRID_HEIGHT_BITS-1:0];
        end
        hds_pkg::REG_DIFFUSION_FACTOR: begin
          diffusion_factor <= cfg_wdata[hds_pkg::FACTOR_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // every accepted item that puts out a cell reserves a queue slot until its result is taken
  assign outstanding   = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(inflight);
  assign s_axis_tready = outstanding < (CNT_W+1)'(DEPTH);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  hds_addr_gen #(
    .MAX_WIDTH (MAX_WIDTH),
    .TEMP_BITS (TEMP_BITS)
  ) u_addr_gen (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .old_temp    (s_axis_tdata[TEMP_BITS-1:0]),
    .drain       (s_axis_tuser),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .ctl         (ctl),
    .cell_col    (cell_col),
    .cell_temp   (cell_temp),
    .wrap_col    (wrap_col)
  );

  hds_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * TEMP_BITS)
  ) u_line_buf (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .ra_en   (ctl.valid),
    .ra_addr (cell_col),
    .ra_data (rd_data),
    .rb_en   (ctl.valid),
    .rb_addr (wrap_col),
    .rb_data (rd_wrap)
  );

  hds_stencil #(
    .MAX_WIDTH (MAX_WIDTH),
    .TEMP_BITS (TEMP_BITS)
  ) u_stencil (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cell_col  (cell_col),
    .cell_temp (cell_temp),
    .factor    (diffusion_factor),
    .rd_data   (rd_data),
    .rd_wrap   (rd_wrap),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .push      (push),
    .push_temp (push_temp),
    .push_last (push_last),
    .inflight  (inflight)
  );

  hds_out_fifo #(
    .DEPTH  (DEPTH),
    .DATA_W (TEMP_BITS)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_temp),
    .push_last (push_last),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_temp),
    .out_last  (m_axis_tlast),
    .count     (fifo_count)
  );

  assign m_axis_tdata = TDATA_W'(out_temp);

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= (CNT_W+1)'(DEPTH))
    else $error("more items in flight than result queue slots");

endmodule

// ===== tb/sv/heat_diffusion_stencil_pass_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for heat_diffusion_stencil_pass: streams grids, drains and noise into
// the block and checks every cell against an in-bench five-point stencil predictor.
// Depends on hds_pkg and the heat_diffusion_stencil_pass RTL.

module heat_diffusion_stencil_pass_tb;

  localparam int TEMP_W          = hds_pkg::DEF_TEMP_BITS;
  localparam int BUS_W           = ((TEMP_W + 7) / 8) * 8;
  localparam int LINE_CELLS      = hds_pkg::DEF_MAX_WIDTH;
  localparam int SETTLE          = 12;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_CYCLES     = 400;
  localparam int ITEMS_PER_PHASE = 180;
  localparam longint TEMP_TOP    = (longint'(1) << TEMP_W) - 1;
  localparam bit [TEMP_W-1:0] TEMP_FULL = '1;

  typedef enum int {PAT_NOISE, PAT_RAILS, PAT_FLAT, PAT_HOT_RIM, PAT_COLD_RIM} pattern_t;

  class stencil_scoreboard;
    typedef struct {
      logic [TEMP_W-1:0] temp;
      logic              last;
    } cell_t;

    bit [TEMP_W-1:0] above_row [LINE_CELLS];
    bit [TEMP_W-1:0] cur_row [LINE_CELLS];
    bit [TEMP_W-1:0] up_val;
    int unsigned col_in;
    int unsigned row_in;
    bit [hds_pkg::GRID_WIDTH_BITS-1:0]  width_reg;
    bit [hds_pkg::GRID_HEIGHT_BITS-1:0] height_reg;
    bit [hds_pkg::FACTOR_BITS-1:0]      factor_reg;
    cell_t due_cells[$];
    int errors;

    function new();
      width_reg  = hds_pkg::RESET_GRID_WIDTH;
      height_reg = hds_pkg::RESET_GRID_HEIGHT;
      factor_reg = hds_pkg::RESET_FACTOR;
      col_in = 0;
      row_in = 0;
      up_val = '0;
      errors = 0;
    endfunction

    function int unsigned grid_cols();
      if (width_reg < hds_pkg::MIN_DIM) return hds_pkg::MIN_DIM;
      if (width_reg > LINE_CELLS) return LINE_CELLS;
      return width_reg;
    endfunction

    function int unsigned grid_rows();
      if (height_reg < hds_pkg::MIN_DIM) return hds_pkg::MIN_DIM;
      return height_reg;
    endfunction

    function int pending();
      return due_cells.size();
    endfunction

    function void write_reg(hds_pkg::cfg_reg_t idx, bit [hds_pkg::CFG_DATA_BITS-1:0] val);
      case (idx)
        hds_pkg::REG_GRID_WIDTH:       width_reg  = val[hds_pkg::GRID_WIDTH_BITS-1:0];
        hds_pkg::REG_GRID_HEIGHT:      height_reg = val[hds_pkg::GRID_HEIGHT_BITS-1:0];
        hds_pkg::REG_DIFFUSION_FACTOR: factor_reg = val[hds_pkg::FACTOR_BITS-1:0];
        default: ;
      endcase
    endfunction

    // old + floor((p*lap + half) / 2^16), clamped to the temperature range
    function bit [TEMP_W-1:0] relax(bit [TEMP_W-1:0] up, bit [TEMP_W-1:0] down,
                                    bit [TEMP_W-1:0] left, bit [TEMP_W-1:0] right,
                                    bit [TEMP_W-1:0] center);
      longint lap;
      longint prod;
      longint sum;
      lap = longint'(up) + longint'(down) + longint'(left) + longint'(right)
            - 4 * longint'(center);
      prod = lap * longint'(factor_reg) + hds_pkg::ROUND_HALF;
      sum = longint'(center) + (prod >>> hds_pkg::FRAC_BITS);
      if (sum < 0) return '0;
      if (sum > TEMP_TOP) return TEMP_FULL;
      return sum[TEMP_W-1:0];
    endfunction

    function void note_input(bit [TEMP_W-1:0] temp_in, bit drain);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      bit [TEMP_W-1:0] v;
      bit [TEMP_W-1:0] res;
      bit [TEMP_W-1:0] center;
      bit have;
      cell_t out_cell;
      w = grid_cols();
      h = grid_rows();
      if (col_in >= w || row_in > h + 1 || (row_in == h + 1 && col_in != 0)) begin
        col_in = 0;
        row_in = 0;
      end
      // drain while data is still expected: dropped
      if (row_in < h && drain) return;
      v = (row_in < h) ? temp_in : '0;
      have = 1'b0;
      r = 0;
      c = 0;
      res = '0;
      if (col_in >= 1 && row_in >= 1) begin
        r = row_in - 1;
        c = col_in - 1;
        center = above_row[c];
        if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
          res = center;
        end else begin
          res = relax(up_val, cur_row[c], above_row[c - 1], cur_row[col_in], center);
        end
        have = 1'b1;
      end else if (col_in == 0 && row_in >= 2) begin
        // end cell of the row two back
        r = row_in - 2;
        c = w - 1;
        res = above_row[c];
        have = 1'b1;
      end
      up_val = above_row[col_in];
      above_row[col_in] = cur_row[col_in];
      cur_row[col_in] = v;
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      if (have) begin
        out_cell.temp = res;
        out_cell.last = (r == h - 1 && c == w - 1);
        due_cells.push_back(out_cell);
        if (out_cell.last) begin
          col_in = 0;
          row_in = 0;
        end
      end
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic [TEMP_W-1:0] temp_out, logic last_out);
      cell_t want;
      if (due_cells.size() == 0) begin
        complain($sformatf("unexpected cell temp %0d last %b", temp_out, last_out));
        return;
      end
      want = due_cells.pop_front();
      if (temp_out !== want.temp || last_out !== want.last) begin
        complain($sformatf("cell mismatch: expected temp %0d last %b, got temp %0d last %b",
                           want.temp, want.last, temp_out, last_out));
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [BUS_W-1:0]                  s_axis_tdata = '0;   // old_temp
  logic                              s_axis_tuser = 1'b0; // drain
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [BUS_W-1:0]                  m_axis_tdata;        // new_temp
  logic                              m_axis_tlast;
  logic                              cfg_we = 1'b0;
  logic [hds_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [hds_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  logic        hold_go = 1'b0;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;
  int unsigned phase_items = 0;
  stencil_scoreboard sb;

  heat_diffusion_stencil_pass u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("heat_diffusion_stencil_pass verification failed");
      $finish;
    end
  end

  // Output side: check accepted items, random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[TEMP_W-1:0], m_axis_tlast);
      if (hold_go && !hold_seen) begin
        hold_seen <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic bit [TEMP_W-1:0] cell_temp(pattern_t pat, int unsigned r, int unsigned c,
                                                int unsigned w, int unsigned h,
                                                bit [TEMP_W-1:0] base);
    bit rim;
    rim = (r == 0 || c == 0 || r == h - 1 || c == w - 1);
    case (pat)
      PAT_RAILS:    return $urandom_range(1) ? TEMP_FULL : '0;
      PAT_FLAT:     return base + TEMP_W'($urandom_range(2));
      PAT_HOT_RIM:  return rim ? TEMP_FULL : '0;
      PAT_COLD_RIM: return rim ? '0 : TEMP_FULL;
      default:      return TEMP_W'($urandom());
    endcase
  endfunction

  function automatic int unsigned pick_factor();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 65535;
      2:       return 32768;
      3:       return 16384;
      default: return $urandom_range(65535);
    endcase
  endfunction

  // tvalid stays high between back-to-back items; only an idle gap lowers it
  task automatic push_cell(bit [TEMP_W-1:0] temp_in, bit drain);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= BUS_W'(temp_in);
    s_axis_tuser  <= drain;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(temp_in, drain);
  endtask

  task automatic send_cells(pattern_t pat, int unsigned count, int unsigned noise_pct,
                            bit [TEMP_W-1:0] base);
    int unsigned w;
    int unsigned h;
    w = sb.grid_cols();
    h = sb.grid_rows();
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(99) < noise_pct) push_cell(TEMP_W'($urandom()), 1'b1);
      push_cell(cell_temp(pat, k / w, k % w, w, h, base), 1'b0);
      phase_items++;
    end
  endtask

  // width+1 flush items; with mixed set, some carry drain=0 and must still flush
  task automatic send_frame(pattern_t pat, int unsigned noise_pct, bit [TEMP_W-1:0] base,
                            bit mixed);
    send_cells(pat, sb.grid_cols() * sb.grid_rows(), noise_pct, base);
    repeat (sb.grid_cols() + 1) begin
      push_cell(TEMP_W'($urandom()), mixed ? 1'($urandom_range(1)) : 1'b1);
      phase_items++;
    end
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_grid(int unsigned w, int unsigned h, int unsigned p);
    hds_pkg::cfg_reg_t order[3];
    int unsigned vals[3];
    order = '{hds_pkg::REG_GRID_WIDTH, hds_pkg::REG_GRID_HEIGHT,
              hds_pkg::REG_DIFFUSION_FACTOR};
    vals = '{w, h, p};
    cfg_we <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_addr  <= order[i];
      cfg_wdata <= hds_pkg::CFG_DATA_BITS'(vals[i]);
      @(posedge clk);
      sb.write_reg(order[i], hds_pkg::CFG_DATA_BITS'(vals[i]));
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_grid();
    int unsigned w;
    int unsigned h;
    w = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
    h = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
    set_grid(w, h, pick_factor());
  endtask

  task automatic random_phase(int src_pct, int sink_pct);
    bit regrid_done;
    int unsigned cols;
    int unsigned cut_col;
    int unsigned cut_row;
    pattern_t pat;
    bit [TEMP_W-1:0] base;
    int unsigned noise;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    phase_items = 0;
    regrid_done = 1'b0;
    while (phase_items < ITEMS_PER_PHASE) begin
      if (!regrid_done && $urandom_range(3) != 0) begin
        quiesce();
        random_grid();
      end
      regrid_done = 1'b0;
      pat = pattern_t'($urandom_range(PAT_COLD_RIM));
      base = TEMP_W'($urandom_range(65533));
      noise = ($urandom_range(3) == 0) ? 15 : 0;
      cols = sb.grid_cols();
      if (cols >= 4 && $urandom_range(9) == 0) begin
        // abandon the frame mid-row, then narrow the grid so the position restarts
        cut_col = $urandom_range(cols - 1, 3);
        cut_row = $urandom_range(sb.grid_rows() - 1);
        send_cells(pat, cut_row * cols + cut_col, noise, base);
        quiesce();
        set_grid($urandom_range(cut_col), $urandom_range(8), pick_factor());
        regrid_done = 1'b1;
      end else begin
        send_frame(pat, noise, base, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // hot rim, cold core, full factor: interior saturates high; leading drain is dropped
    set_grid(0, 0, 65535);
    push_cell(TEMP_FULL, 1'b1);
    send_frame(PAT_HOT_RIM, 0, '0, 1'b1);
    // partial row, then a narrower grid forces a restart at cell zero
    quiesce();
    set_grid(5, 2, 65535);
    send_cells(PAT_RAILS, 4, 0, '0);
    quiesce();
    set_grid(2, 3, 65535);
    send_frame(PAT_COLD_RIM, 0, '0, 1'b0);

    // wider rows, then a taller grid
    quiesce();
    set_grid(40, 3, 0);
    send_frame(PAT_NOISE, 0, '0, 1'b1);
    quiesce();
    set_grid(3, 12, 16384);
    send_frame(PAT_FLAT, 0, 16'd30000, 1'b1);

    // long output hold-off while input keeps coming: queue fills, input stalls
    quiesce();
    set_grid(16, 8, 16384);
    hold_go <= 1'b1;
    send_frame(PAT_NOISE, 0, '0, 1'b0);

    random_phase(0, 0);
    random_phase(66, 0);
    random_phase(0, 66);
    random_phase(31, 31);

    quiesce();
    if (sb.errors == 0) begin
      $display("heat_diffusion_stencil_pass verification clean");
    end else begin
      $display("heat_diffusion_stencil_pass verification failed");
    end
    $finish;
  end

endmodule
